FILE: hw/rtl/clbp_pkg.sv
// Shared types and fixed field widths for the circular LBP code block.
package clbp_pkg;

  // Fixed field widths of the pixel and code streams
  localparam int PIXEL_W   = 8;
  localparam int CODE_W    = 16;
  localparam int ROW_W     = 12;
  localparam int OUTCOL_W  = 10;
  localparam int FWIDTH_W  = 11;
  localparam int FHEIGHT_W = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  // Output tdata: code, row and column packed, padded to whole bytes
  localparam int OUT_DATA_W = 40;
  localparam int IN_DATA_W  = 8;

  // Register reset values
  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Sine/cosine constants in Q30 used when the tap table is built
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

endpackage

FILE: hw/rtl/circular_lbp_code.sv
// Circular LBP code generator: line memory, sliding window and sampling lanes.
//
// Gray pixels enter on the in_ stream (tdata = pixel) in raster order, frame
// after frame. For every center at least RADIUS away from each border one
// code leaves on the out_ stream; border pixels produce nothing. Bit n of the
// code is set when the bilinear sample at angle 2*pi*n/NEIGHBORS on the
// circle of RADIUS is greater than or equal to the center pixel.
// out_tlast marks the last interior code of a frame.
// Frame size comes from the cfg_ write port (index 0 width, index 1 height);
// a write restarts the frame at row 0, column 0.
// Throughput: one pixel per clock while the receiver keeps out_tready high. Each
// pixel makes one read and one write-back of its column word in the line memory, which sets the rate.
// A code is registered in s1, then s2, then the output register after the
// transaction that completes its window.
// While the receiver stalls, in_tready stays high until the three pipeline
// registers are full, then drops; nothing is lost or repeated.
// Reset clears the counters and valid flags and restores a 640x480 frame.
// The line memory needs no clearing: every window read in a frame only
// touches pixels written earlier in the same frame.
module circular_lbp_code #(
  parameter int RADIUS           = 1,
  parameter int NEIGHBORS        = 8,
  parameter int MAX_WIDTH        = 1024,
  parameter int WEIGHT_FRAC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Pixel input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [clbp_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] pixel
  // Code output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] lbp_code, [27:16] center_row, [37:28] center_col, [39:38] zero
  output logic [clbp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,  // last_of_frame
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [clbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clbp_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int SPAN    = 2 * RADIUS;             // rows kept in the line memory
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WGT_W   = WEIGHT_FRAC_BITS + 1;
  localparam int PROD_W  = WEIGHT_FRAC_BITS + clbp_pkg::PIXEL_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int PIX_W   = clbp_pkg::PIXEL_W;
  localparam int ROW_W   = clbp_pkg::ROW_W;

  // ---------------------------------------------------------------------
  // Tap table, built at elaboration.
  // sel 0..3: row_lo, row_hi, col_lo, col_hi; sel 4..7: the four weights
  // ordered (row_lo,col_lo) (row_lo,col_hi) (row_hi,col_lo) (row_hi,col_hi).
  // ---------------------------------------------------------------------
  function automatic longint tap_info(int n, int sel);
    longint theta, x2, ts, tc, ss, cc, sn, cs;
    longint pos [2];
    longint lo [2];
    longint hi [2];
    longint frac [2];
    longint f, rem, one, sum;
    longint w [4];
    int q, r, big;
    q  = (4 * n) / NEIGHBORS;
    r  = 4 * n - q * NEIGHBORS;
    theta = (clbp_pkg::Q30_HALF_PI * longint'(r)) / NEIGHBORS;
    x2 = (theta * theta) >>> 30;
    ts = theta;
    tc = clbp_pkg::Q30_ONE;
    ss = theta;
    cc = clbp_pkg::Q30_ONE;
    // Taylor terms to the 15th power
    ts = ((ts * x2) >>> 30) / 6;   tc = ((tc * x2) >>> 30) / 2;   ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 20;  tc = ((tc * x2) >>> 30) / 12;  ss += ts; cc += tc;
    ts = ((ts * x2) >>> 30) / 42;  tc = ((tc * x2) >>> 30) / 30;  ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 72;  tc = ((tc * x2) >>> 30) / 56;  ss += ts; cc += tc;
    ts = ((ts * x2) >>> 30) / 110; tc = ((tc * x2) >>> 30) / 90;  ss -= ts; cc -= tc;
    ts = ((ts * x2) >>> 30) / 156; tc = ((tc * x2) >>> 30) / 132; ss += ts; cc += tc;
    ts = ((ts * x2) >>> 30) / 210; tc = ((tc * x2) >>> 30) / 182; ss -= ts; cc -= tc;
    if (ss < 0) ss = 0;
    if (ss > clbp_pkg::Q30_ONE) ss = clbp_pkg::Q30_ONE;
    if (cc < 0) cc = 0;
    if (cc > clbp_pkg::Q30_ONE) cc = clbp_pkg::Q30_ONE;
    // Quadrant unfolding
    case (q % 4)
      0: begin sn = ss;  cs = cc;  end
      1: begin sn = cc;  cs = -ss; end
      2: begin sn = -ss; cs = -cc; end
      default: begin sn = -cc; cs = ss; end
    endcase
    // Index 0 is the row axis, index 1 the column axis
    pos[0] = longint'(RADIUS) * cs;
    pos[1] = -(longint'(RADIUS) * sn);
    for (int a = 0; a < 2; a++) begin
      if (pos[a] >= 0) f = pos[a] >>> 30;
      else f = -((-pos[a] + clbp_pkg::Q30_ONE - 1) >>> 30);
      rem     = pos[a] - f * clbp_pkg::Q30_ONE;
      lo[a]   = f;
      hi[a]   = f + ((rem != 0) ? 1 : 0);
      frac[a] = (rem + (longint'(1) <<< (29 - WEIGHT_FRAC_BITS))) >>> (30 - WEIGHT_FRAC_BITS);
    end
    one  = longint'(1) <<< WEIGHT_FRAC_BITS;
    w[0] = ((one - frac[1]) * (one - frac[0]) + (one >>> 1)) >>> WEIGHT_FRAC_BITS;
    w[1] = (frac[1] * (one - frac[0]) + (one >>> 1)) >>> WEIGHT_FRAC_BITS;
    w[2] = ((one - frac[1]) * frac[0] + (one >>> 1)) >>> WEIGHT_FRAC_BITS;
    w[3] = (frac[1] * frac[0] + (one >>> 1)) >>> WEIGHT_FRAC_BITS;
    // Residual goes to the largest weight, first of equals
    big = 0;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      sum += w[k];
      if (w[k] > w[big]) big = k;
    end
    w[big] = w[big] + one - sum;
    case (sel)
      0: return lo[0];
      1: return hi[0];
      2: return lo[1];
      3: return hi[1];
      4: return w[0];
      5: return w[1];
      6: return w[2];
      default: return w[3];
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [clbp_pkg::FWIDTH_W-1:0]  frame_width_r;
  logic [clbp_pkg::FHEIGHT_W-1:0] frame_height_r;
  logic                           cfg_restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= clbp_pkg::FRAME_WIDTH_RST;
      frame_height_r <= clbp_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (clbp_pkg::cfg_idx_t'(cfg_index))
        clbp_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[clbp_pkg::FWIDTH_W-1:0];
        clbp_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[clbp_pkg::FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Every valid index restarts the frame
  assign cfg_restart = cfg_we;

  // Last column and row in use (width clamped to 1..MAX_WIDTH, height to >= 1)
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (frame_width_r == '0) begin
      col_last = '0;
    end else if ({2'b00, frame_width_r} > 13'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_W'(frame_width_r - 1'b1);
    end
    if (frame_height_r == '0) begin
      row_last = '0;
    end else begin
      row_last = frame_height_r - 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain: input -> s1 (memory data) -> s2 (products) -> output
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_emit_r, s2_valid_r, out_valid_r;
  logic s1_go, s2_go, out_free, s2_free, in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_go     = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || s2_go;
  assign s1_go     = s1_valid_r && (!s1_emit_r || s2_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------
  // Raster counters
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] row_count_r;
  logic [COL_W-1:0] col_count_r;
  logic             at_emit, at_last;

  assign at_emit = (row_count_r >= ROW_W'(SPAN)) && ({1'b0, col_count_r} >= (COL_W + 1)'(SPAN));
  assign at_last = (row_count_r == row_last) && (col_count_r == col_last);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      row_count_r <= '0;
      col_count_r <= '0;
    end else if (in_acc) begin
      if (col_count_r == col_last) begin
        col_count_r <= '0;
        row_count_r <= (row_count_r == row_last) ? '0 : row_count_r + 1'b1;
      end else begin
        col_count_r <= col_count_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: one word per column holding the SPAN rows above
  // ---------------------------------------------------------------------
  logic [SPAN-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [SPAN-1:0][PIX_W-1:0] mem_q_r;
  logic [SPAN-1:0][PIX_W-1:0] fwd_word_r;
  logic [SPAN-1:0][PIX_W-1:0] new_word;
  logic                       fwd_r;

  // Stage 1 payload
  logic [PIX_W-1:0]           s1_pix_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [ROW_W-1:0]           s1_crow_r;
  logic [COL_W-1:0]           s1_ccol_r;
  logic                       s1_last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_q_r <= line_mem[col_count_r];
    end
    if (s1_go) begin
      line_mem[s1_col_r] <= new_word;
    end
  end

  // Write-back of the item in s1 overlapping a read of the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_acc) begin
      fwd_r <= s1_go && (s1_col_r == col_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_word_r <= new_word;
      s1_pix_r   <= in_tdata[PIX_W-1:0];
      s1_col_r   <= col_count_r;
      s1_crow_r  <= row_count_r - ROW_W'(RADIUS);
      s1_ccol_r  <= col_count_r - COL_W'(RADIUS);
      s1_last_r  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      s1_emit_r  <= at_emit;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Sliding window: column SPAN is the newest
  // ---------------------------------------------------------------------
  logic [SPAN:0][SPAN:0][PIX_W-1:0] win_r;
  logic [SPAN:0][SPAN:0][PIX_W-1:0] win_nxt;
  logic [SPAN-1:0][PIX_W-1:0]       col_word;
  logic [SPAN:0][PIX_W-1:0]         new_col;

  assign col_word = fwd_r ? fwd_word_r : mem_q_r;

  always_comb begin
    for (int i = 0; i < SPAN; i++) begin
      new_col[i] = col_word[i];
    end
    new_col[SPAN] = s1_pix_r;
    // Column word moves up one row with the new pixel at the bottom
    for (int i = 0; i < SPAN; i++) begin
      new_word[i] = new_col[i+1];
    end
    for (int i = 0; i <= SPAN; i++) begin
      for (int j = 0; j < SPAN; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
      win_nxt[i][SPAN] = new_col[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2 payload and output registers
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0]            s2_center_r;
  logic [ROW_W-1:0]            s2_crow_r;
  logic [COL_W-1:0]            s2_ccol_r;
  logic                        s2_last_r;
  logic                        s2_load;
  logic [clbp_pkg::CODE_W-1:0] code_nxt;
  logic [clbp_pkg::CODE_W-1:0] out_code_r;
  logic [ROW_W-1:0]            out_row_r;
  logic [clbp_pkg::OUTCOL_W-1:0] out_col_r;
  logic                        out_last_r;

  assign s2_load = s1_go && s1_emit_r;

  // Per-neighbor lanes: four weighted taps, then sum and compare
  for (genvar n = 0; n < NEIGHBORS; n++) begin : g_lane
    localparam int RLO = RADIUS + int'(tap_info(n, 0));
    localparam int RHI = RADIUS + int'(tap_info(n, 1));
    localparam int CLO = RADIUS + int'(tap_info(n, 2));
    localparam int CHI = RADIUS + int'(tap_info(n, 3));
    localparam logic [WGT_W-1:0] W0 = WGT_W'(tap_info(n, 4));
    localparam logic [WGT_W-1:0] W1 = WGT_W'(tap_info(n, 5));
    localparam logic [WGT_W-1:0] W2 = WGT_W'(tap_info(n, 6));
    localparam logic [WGT_W-1:0] W3 = WGT_W'(tap_info(n, 7));

    logic [PROD_W-1:0] prod_r [4];
    logic [ACC_W-1:0]  acc;

    always_ff @(posedge clk) begin
      if (s2_load) begin
        prod_r[0] <= PROD_W'(W0) * PROD_W'(win_nxt[RLO][CLO]);
        prod_r[1] <= PROD_W'(W1) * PROD_W'(win_nxt[RLO][CHI]);
        prod_r[2] <= PROD_W'(W2) * PROD_W'(win_nxt[RHI][CLO]);
        prod_r[3] <= PROD_W'(W3) * PROD_W'(win_nxt[RHI][CHI]);
      end
    end

    assign acc = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1])
               + ACC_W'(prod_r[2]) + ACC_W'(prod_r[3]);
    assign code_nxt[n] = acc >= (ACC_W'(s2_center_r) << WEIGHT_FRAC_BITS);
  end

  // Code bits above the neighbor count stay zero
  for (genvar n = NEIGHBORS; n < clbp_pkg::CODE_W; n++) begin : g_zero
    assign code_nxt[n] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_center_r <= win_nxt[RADIUS][RADIUS];
      s2_crow_r   <= s1_crow_r;
      s2_ccol_r   <= s1_ccol_r;
      s2_last_r   <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_code_r <= code_nxt;
      out_row_r  <= s2_crow_r;
      out_col_r  <= clbp_pkg::OUTCOL_W'(s2_ccol_r);
      out_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_code_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the circular LBP code generator with a bit-true predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clbp_pkg::*;

  localparam int RADIUS    = 1;
  localparam int NEIGHBORS = 8;
  localparam int MAX_WIDTH = 1024;
  localparam int FRAC_BITS = 12;
  localparam int RING_ROWS = 2 * RADIUS + 1;
  // idle cycles before a register write
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 200;
  localparam int HOLD_AFTER    = 300;

  // One code as it leaves the block
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [ROW_W-1:0]    row;
    logic [OUTCOL_W-1:0] col;
    logic                last;
  } lbp_result_t;

  // Directed stimulus rows
  typedef enum logic [1:0] {ROW_FILL, ROW_CHECK, ROW_CONFIG} dir_kind_t;
  typedef struct packed {
    dir_kind_t   kind;
    logic [15:0] count;
    logic [7:0]  pix;
    lbp_result_t want;
    cfg_idx_t    sel;
    logic [11:0] value;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] pixel
  logic                  out_tvalid;
  logic                  out_tready;
  // [15:0] lbp_code, [27:16] center_row, [37:28] center_col, [39:38] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;  // last_of_frame
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  circular_lbp_code #(
    .RADIUS          (RADIUS),
    .NEIGHBORS       (NEIGHBORS),
    .MAX_WIDTH       (MAX_WIDTH),
    .WEIGHT_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: pixel ring, counters, frame registers, sampling taps
  logic [7:0]      pixel_rows [RING_ROWS][MAX_WIDTH];
  int unsigned     row_cnt;
  int unsigned     col_cnt;
  logic [10:0]     frame_width_q;
  logic [11:0]     frame_height_q;
  int              tap_row_lo [NEIGHBORS];
  int              tap_row_hi [NEIGHBORS];
  int              tap_col_lo [NEIGHBORS];
  int              tap_col_hi [NEIGHBORS];
  int unsigned     tap_w      [NEIGHBORS][4];

  lbp_result_t     pending_codes [$];
  dir_row_t        dir_rows [$];
  int              mismatch_count;
  int              codes_seen;
  int              tx_count;
  int              rx_count;
  bit              tx_burst;
  bit              rx_burst;
  lbp_result_t     got_code;
  lbp_result_t     want_code;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("[circular_lbp_code] ERROR");
    $finish;
  end

  // sin and cos of an angle inside the first quadrant, Q30 Taylor series
  function automatic void quarter_sin_cos(input longint unsigned theta,
                                          output longint s_q, output longint c_q);
    longint unsigned x2, ts, tc;
    longint ss, cc;
    x2 = (theta * theta) >> 30;
    ts = theta;
    tc = Q30_ONE;
    ss = longint'(theta);
    cc = Q30_ONE;
    for (longint unsigned k = 1; k <= 7; k++) begin
      ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= longint'(ts);
        cc -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cc += longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (ss > Q30_ONE) ss = Q30_ONE;
    if (cc < 0) cc = 0;
    if (cc > Q30_ONE) cc = Q30_ONE;
    s_q = ss;
    c_q = cc;
  endfunction

  // Signed Q30 offset -> floor, ceil and rounded weight fraction
  function automatic void split_offset(input longint p, output int lo, output int hi,
                                       output int unsigned frac);
    longint f;
    longint unsigned rem;
    if (p >= 0) f = p / Q30_ONE;
    else f = -((-p + Q30_ONE - 1) / Q30_ONE);
    rem = p - f * Q30_ONE;
    lo = int'(f);
    hi = int'(f) + ((rem != 0) ? 1 : 0);
    frac = int'((rem + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  function automatic int unsigned round_mul(input int unsigned a, input int unsigned b);
    longint unsigned prod;
    prod = longint'(a) * b;
    return int'((prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  endfunction

  // Offsets and bilinear weights of every neighbor sample
  function automatic void build_sampling_taps();
    int unsigned q, r, tx, ty, big, total, one;
    longint s_q, c_q, sn, cs;
    one = 1 << FRAC_BITS;
    for (int n = 0; n < NEIGHBORS; n++) begin
      q = (4 * n) / NEIGHBORS;
      r = 4 * n - q * NEIGHBORS;
      quarter_sin_cos(Q30_HALF_PI * r / NEIGHBORS, s_q, c_q);
      case (q % 4)
        0: begin sn = s_q;  cs = c_q;  end
        1: begin sn = c_q;  cs = -s_q; end
        2: begin sn = -s_q; cs = -c_q; end
        default: begin sn = -c_q; cs = s_q; end
      endcase
      split_offset(-(RADIUS * sn), tap_col_lo[n], tap_col_hi[n], tx);
      split_offset(RADIUS * cs, tap_row_lo[n], tap_row_hi[n], ty);
      tap_w[n][0] = round_mul(one - tx, one - ty);
      tap_w[n][1] = round_mul(tx, one - ty);
      tap_w[n][2] = round_mul(one - tx, ty);
      tap_w[n][3] = round_mul(tx, ty);
      // residual goes to the largest weight, the first one on a tie
      big = 0;
      total = 0;
      for (int k = 0; k < 4; k++) begin
        total += tap_w[n][k];
        if (tap_w[n][k] > tap_w[n][big]) big = k;
      end
      tap_w[n][big] = tap_w[n][big] + one - total;
    end
  endfunction

  function automatic longint unsigned ring_pixel(input int unsigned crow, input int dr,
                                                 input int unsigned ccol, input int dc);
    int unsigned rr, cl;
    rr = crow + dr;
    cl = ccol + dc;
    return pixel_rows[rr % RING_ROWS][cl % MAX_WIDTH];
  endfunction

  // Store one pixel and work out the code it completes, if any
  function automatic void compute_lbp_code(input logic [7:0] pix, output bit has,
                                           output lbp_result_t res);
    int unsigned w, h, r, c, cr, cc;
    longint unsigned acc, center;
    logic [CODE_W-1:0] code;
    w = frame_width_q;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = frame_height_q;
    if (h < 1) h = 1;
    r = row_cnt;
    c = col_cnt;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    pixel_rows[r % RING_ROWS][c] = pix;
    has = 1'b0;
    res = '0;
    if (r >= 2 * RADIUS && c >= 2 * RADIUS) begin
      cr = r - RADIUS;
      cc = c - RADIUS;
      center = ring_pixel(cr, 0, cc, 0);
      code = '0;
      for (int n = 0; n < NEIGHBORS; n++) begin
        acc = tap_w[n][0] * ring_pixel(cr, tap_row_lo[n], cc, tap_col_lo[n])
            + tap_w[n][1] * ring_pixel(cr, tap_row_lo[n], cc, tap_col_hi[n])
            + tap_w[n][2] * ring_pixel(cr, tap_row_hi[n], cc, tap_col_lo[n])
            + tap_w[n][3] * ring_pixel(cr, tap_row_hi[n], cc, tap_col_hi[n]);
        if (acc >= (center << FRAC_BITS)) code[n] = 1'b1;
      end
      res.code = code;
      res.row  = cr[ROW_W-1:0];
      res.col  = cc[OUTCOL_W-1:0];
      res.last = (r == h - 1) && (c == w - 1);
      has = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_cnt = r;
    col_cnt = c;
  endfunction

  // Directed row builders
  function automatic void add_fill(input int count, input logic [7:0] pix);
    dir_row_t e;
    e = '0;
    e.kind  = ROW_FILL;
    e.count = count[15:0];
    e.pix   = pix;
    dir_rows.push_back(e);
  endfunction

  function automatic void add_check(input logic [7:0] pix, input logic [15:0] code,
                                    input int row, input int col, input bit last);
    dir_row_t e;
    e = '0;
    e.kind      = ROW_CHECK;
    e.count     = 1;
    e.pix       = pix;
    e.want.code = code;
    e.want.row  = row[ROW_W-1:0];
    e.want.col  = col[OUTCOL_W-1:0];
    e.want.last = last;
    dir_rows.push_back(e);
  endfunction

  function automatic void add_config(input cfg_idx_t sel, input logic [11:0] value);
    dir_row_t e;
    e = '0;
    e.kind  = ROW_CONFIG;
    e.sel   = sel;
    e.value = value;
    dir_rows.push_back(e);
  endfunction

  // Pixel content: uniform, two-level, low-noise and near-flat images
  function automatic logic [7:0] pick_pixel(input int mode, input logic [7:0] base);
    int v;
    case (mode)
      0: v = $urandom_range(0, 255);
      1: v = $urandom_range(0, 1) ? base : base + 1;
      2: begin
        v = int'(base) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : base;
    endcase
    return v[7:0];
  endfunction

  // Offer one pixel, wait for its transaction, then predict
  task automatic send_pixel(input logic [7:0] pix, input bit typed, input lbp_result_t want);
    int gap;
    bit has;
    lbp_result_t res;
    if (tx_count % 50 == 0) tx_burst = ($urandom_range(0, 2) == 0);
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    tx_count++;
    compute_lbp_code(pix, has, res);
    if (typed) pending_codes.push_back(want);
    else if (has) pending_codes.push_back(res);
  endtask

  // Stop offering and wait for every outstanding code
  task automatic drain_codes();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  // Register write on an idle block; a write also restarts the frame
  task automatic write_frame_reg(input cfg_idx_t sel, input logic [11:0] value);
    drain_codes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_FRAME_WIDTH) frame_width_q = value[10:0];
    else frame_height_q = value;
    row_cnt = 0;
    col_cnt = 0;
  endtask

  // One frame setting with random pixel content
  task automatic run_frames(input bit set_w, input logic [11:0] w_val, input bit set_h,
                            input logic [11:0] h_val, input int count, input int pause_at);
    int mode;
    logic [7:0] base;
    if (set_w) write_frame_reg(CFG_FRAME_WIDTH, w_val);
    if (set_h) write_frame_reg(CFG_FRAME_HEIGHT, h_val);
    mode = $urandom_range(0, 3);
    base = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_codes();
      if (i % 64 == 63) begin
        mode = $urandom_range(0, 3);
        base = $urandom_range(0, 255);
      end
      send_pixel(pick_pixel(mode, base), 1'b0, '0);
    end
  endtask

  // Output check: every code transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      codes_seen++;
      got_code.code = out_tdata[15:0];
      got_code.row  = out_tdata[27:16];
      got_code.col  = out_tdata[37:28];
      got_code.last = out_tlast;
      if (pending_codes.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected code %h row %0d col %0d last %0b",
                   got_code.code, got_code.row, got_code.col, got_code.last);
        mismatch_count++;
      end else begin
        want_code = pending_codes.pop_front();
        if (got_code !== want_code) begin
          if (mismatch_count < 10)
            $display("mismatch: expected code %h row %0d col %0d last %0b, got code %h row %0d col %0d last %0b",
                     want_code.code, want_code.row, want_code.col, want_code.last,
                     got_code.code, got_code.row, got_code.col, got_code.last);
          mismatch_count++;
        end
      end
    end
  end

  // Code receiver: random stalls, bursts, and one long hold-off
  initial begin : code_sink
    int gap;
    bit held;
    out_tready <= 1'b0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_count % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 13);
      if (!held && codes_seen >= HOLD_AFTER) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_count++;
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [7:0] ramp [9];
    logic [7:0] near_tie [9];
    int w, h;
    ramp     = '{8'd10, 8'd200, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
    near_tie = '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd101, 8'd99, 8'd100, 8'd100};
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FRAME_WIDTH;
    cfg_wdata      <= '0;
    rst_n          <= 1'b0;
    mismatch_count = 0;
    codes_seen     = 0;
    tx_count       = 0;
    rx_count       = 0;
    row_cnt        = 0;
    col_cnt        = 0;
    frame_width_q  = FRAME_WIDTH_RST;
    frame_height_q = FRAME_HEIGHT_RST;
    build_sampling_taps();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset frame is 640 wide: first interior code comes at row 2, column 2
    add_fill(2 * 640 + 2, 8'd0);
    add_check(8'd0, 16'h00FF, 1, 1, 1'b0);
    // Smallest frame that yields a code; bit 11 of the width write is dropped
    add_config(CFG_FRAME_WIDTH, 12'h803);
    add_config(CFG_FRAME_HEIGHT, 12'd3);
    // Bright center on black
    add_fill(4, 8'd0);
    add_fill(1, 8'd255);
    add_fill(3, 8'd0);
    add_check(8'd0, 16'h0000, 1, 1, 1'b1);
    // Black center on white
    add_fill(4, 8'd255);
    add_fill(1, 8'd0);
    add_fill(3, 8'd255);
    add_check(8'd255, 16'h00FF, 1, 1, 1'b1);
    // Flat white: every sample ties with the center
    add_fill(8, 8'd255);
    add_check(8'd255, 16'h00FF, 1, 1, 1'b1);
    foreach (ramp[i]) add_fill(1, ramp[i]);
    foreach (near_tie[i]) add_fill(1, near_tie[i]);

    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        ROW_CONFIG: write_frame_reg(dir_rows[k].sel, dir_rows[k].value);
        ROW_CHECK:  send_pixel(dir_rows[k].pix, 1'b1, dir_rows[k].want);
        default:    repeat (dir_rows[k].count) send_pixel(dir_rows[k].pix, 1'b0, '0);
      endcase
    end

    // Random frames: extremes of both registers first
    run_frames(1'b1, 12'd16, 1'b1, 12'd6, 16 * 6 * 2, -1);
    run_frames(1'b1, 12'd1024, 1'b1, 12'd3, 3 * 1024, 2600);
    run_frames(1'b1, 12'h803, 1'b1, 12'd4095, 3 * 4095, -1);
    run_frames(1'b1, 12'd2047, 1'b1, 12'd4, 2 * 1024 + 10, -1);
    // Frames too small for any code, then the smallest frame that has one
    run_frames(1'b1, 12'd0, 1'b0, 12'd0, 20, -1);
    run_frames(1'b1, 12'd2, 1'b0, 12'd0, 12, -1);
    run_frames(1'b1, 12'd5, 1'b1, 12'd0, 12, -1);
    run_frames(1'b0, 12'd0, 1'b1, 12'd1, 12, -1);
    run_frames(1'b0, 12'd0, 1'b1, 12'd2, 15, -1);
    run_frames(1'b1, 12'd3, 1'b1, 12'd3, 9 * 4, -1);
    for (int p = 0; p < 14; p++) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      run_frames(1'b1, 12'(w), 1'b1, 12'(h),
                 w * h * $urandom_range(1, 3) + $urandom_range(0, w), -1);
    end

    // Let the last codes come out, then look for strays
    drain_codes();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("[circular_lbp_code] OK");
    end else begin
      $display("[circular_lbp_code] ERROR");
    end
    $finish;
  end

endmodule
